/* hdl/hpf_pkg.sv */
// types and constants shared by the harmonic pair force block
`timescale 1ns / 1ps
package hpf_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 31;

	localparam int MOD_STEPS  = 32;
	localparam int ROOT_STEPS = 31;
	localparam int TU_STEPS   = 25;
	localparam int K_STEPS    = 55;
	localparam int NSTG       = 1 + MOD_STEPS + 4 + 1 + ROOT_STEPS + 1 + TU_STEPS + 1 + 1
		+ K_STEPS + 2;

	localparam logic [30:0] ONE_Q24 = 31'h100_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOX_X = 4'd0,
		CFG_BOX_Y = 4'd1,
		CFG_BOX_Z = 4'd2,
		CFG_STIFF = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] first_z;
		logic [30:0]        first_radius;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
		logic signed [31:0] second_z;
		logic [30:0]        second_radius;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic [31:0]        pair_energy;
		logic               in_contact;
	} res_t;

endpackage

/* hdl/hpf_if.sv */
// handshake channels of the harmonic pair force block
`timescale 1ns / 1ps
interface hpf_pair_if;
	import hpf_pkg::*;
	logic  valid;
	logic  ready;
	pair_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hpf_res_if;
	import hpf_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hpf_cfg_if;
	import hpf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* hdl/harmonic_pair_force_core.sv */
// harmonic soft-sphere pair force core: minimum image, overlap test, force and energy
// One pair item enters per cycle unless the pipeline holds. The edge that accepts it loads the
// first of 154 pipeline stages, and the output register takes its result from the last stage.
// Every long operation is unrolled one bit per stage: the minimum-image remainder (32 stages),
// the square root (31), the overlap and unit-vector quotients (25, side by side) and the force
// quotient (55), which is the longest run. The pipeline holds only when its last stage is full
// and the output register is still waiting to be taken. Configuration writes are taken in every
// cycle and must be made while no item is in flight.
`timescale 1ns / 1ps
module harmonic_pair_force_core (
	input logic clk,
	input logic arst_n,
	hpf_cfg_if.sink cfg,
	hpf_pair_if.sink pair,
	hpf_res_if.source result
);
	import hpf_pkg::*;

	typedef struct packed {
		logic [30:0] rem;
		logic [31:0] dvd;
		logic [31:0] len;
		logic        neg;
	} mod_ax_t;

	typedef struct packed {
		mod_ax_t [2:0] ax;
		logic [31:0]   sig;
	} mod_t;

	typedef struct packed {
		logic [2:0][31:0] m0;
		logic [2:0][31:0] len;
		logic [31:0]      sig;
	} fx_t;

	typedef struct packed {
		logic [2:0][30:0] mag;
		logic [2:0]       sgn;
		logic [31:0]      sig;
	} geo_t;

	typedef struct packed {
		logic [2:0][60:0] sq;
		logic [63:0]      ss;
		geo_t             g;
	} sq_t;

	typedef struct packed {
		logic [61:0] r2;
		logic [63:0] ss;
		geo_t        g;
	} r2_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] root;
		logic [61:0] rad;
		logic        contact;
		geo_t        g;
	} rt_t;

	typedef struct packed {
		logic [31:0]      trem;
		logic [24:0]      tbits;
		logic [24:0]      tq;
		logic [2:0][30:0] urem;
		logic [2:0][24:0] ubits;
		logic [2:0][24:0] uq;
		logic [30:0]      root;
		logic             rz;
		logic             contact;
		logic [2:0]       sgn;
		logic [31:0]      sig;
	} tu_t;

	typedef struct packed {
		logic [54:0]      p;
		logic [24:0]      t2;
		logic [2:0][24:0] u;
		logic             rz;
		logic             contact;
		logic [2:0]       sgn;
		logic [31:0]      sig;
	} x_t;

	typedef struct packed {
		logic [31:0]      krem;
		logic [54:0]      kbits;
		logic [54:0]      kq;
		logic [30:0]      energy;
		logic [2:0][24:0] u;
		logic             rz;
		logic             contact;
		logic [2:0]       sgn;
		logic [31:0]      sig;
	} k_t;

	typedef struct packed {
		logic [2:0][55:0] hi;
		logic [2:0][24:0] lo;
		logic [30:0]      energy;
		logic             rz;
		logic             contact;
		logic [2:0]       sgn;
	} fm_t;

	typedef struct packed {
		logic [2:0][55:0] prod;
		logic [30:0]      energy;
		logic             rz;
		logic             contact;
		logic [2:0]       sgn;
	} fs_t;

	logic [30:0] box_q [3];
	logic [30:0] stiff_q;

	logic [NSTG-1:0] vld_s;
	logic            out_vld_q;
	res_t            out_data_q;
	logic            en;
	logic            load_out;

	mod_t mod_s [0:MOD_STEPS];
	fx_t  f1_s;
	geo_t f2_s;
	sq_t  sq_s;
	r2_t  sum_s;
	rt_t  rt_s [0:ROOT_STEPS];
	tu_t  tu_s [0:TU_STEPS];
	x_t   x_s;
	k_t   k_s [0:K_STEPS];
	fm_t  fm_s;
	fs_t  fs_s;

	logic signed [31:0] pa [3];
	logic signed [31:0] pb [3];
	logic signed [32:0] dif [3];
	logic [32:0]        dabs [3];
	mod_t               mod_in;
	fx_t                f1_nx;
	geo_t               f2_nx;
	sq_t                sq_nx;
	r2_t                sum_nx;
	rt_t                rt_in;
	tu_t                tu_in;
	logic [31:0]        diff;
	x_t                 x_nx;
	logic [49:0]        tt;
	k_t                 k_in;
	logic [55:0]        eprod;
	fm_t                fm_nx;
	logic [48:0]        lp [3];
	fs_t                fs_nx;
	res_t               out_nx;
	logic [31:0]        frc [3];
	logic [31:0]        pm [3];

	assign load_out = !out_vld_q || result.ready;
	assign en = load_out || !vld_s[NSTG-1];
	assign pair.ready = en;
	assign cfg.ready = 1'b1;
	assign result.valid = out_vld_q;
	assign result.data = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q[0] <= ONE_Q24;
			box_q[1] <= ONE_Q24;
			box_q[2] <= ONE_Q24;
			stiff_q <= ONE_Q24;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_BOX_X: begin
					box_q[0] <= cfg.data;
				end
				CFG_BOX_Y: begin
					box_q[1] <= cfg.data;
				end
				CFG_BOX_Z: begin
					box_q[2] <= cfg.data;
				end
				CFG_STIFF: begin
					stiff_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_s <= {vld_s[NSTG-2:0], pair.valid};
			end
			if (load_out) begin
				out_vld_q <= vld_s[NSTG-1];
			end
		end
	end

	// entry: separation and its magnitude
	assign pa[0] = pair.data.first_x;
	assign pa[1] = pair.data.first_y;
	assign pa[2] = pair.data.first_z;
	assign pb[0] = pair.data.second_x;
	assign pb[1] = pair.data.second_y;
	assign pb[2] = pair.data.second_z;

	always_comb begin
		mod_in.sig = {1'b0, pair.data.first_radius} + {1'b0, pair.data.second_radius};
		for (int a = 0; a < 3; a++) begin
			dif[a] = {pa[a][31], pa[a]} - {pb[a][31], pb[a]};
			dabs[a] = dif[a][32] ? 33'(-dif[a]) : 33'(dif[a]);
			mod_in.ax[a].rem = '0;
			mod_in.ax[a].dvd = dabs[a][31:0];
			mod_in.ax[a].neg = dif[a][32];
			mod_in.ax[a].len = (box_q[a] == '0) ? 32'h8000_0000 : {1'b0, box_q[a]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mod_s[0] <= mod_in;
		end
	end

	// remainder of the magnitude by the box side, one bit per stage
	for (genvar j = 1; j <= MOD_STEPS; j++) begin : g_mod
		mod_t        nx;
		logic [31:0] sh [3];
		always_comb begin
			nx = mod_s[j-1];
			for (int a = 0; a < 3; a++) begin
				sh[a] = {mod_s[j-1].ax[a].rem, mod_s[j-1].ax[a].dvd[31]};
				if (sh[a] >= mod_s[j-1].ax[a].len) begin
					nx.ax[a].rem = 31'(sh[a] - mod_s[j-1].ax[a].len);
				end else begin
					nx.ax[a].rem = sh[a][30:0];
				end
				nx.ax[a].dvd = {mod_s[j-1].ax[a].dvd[30:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				mod_s[j] <= nx;
			end
		end
	end

	// floor modulo, then fold to the nearest image
	always_comb begin
		f1_nx.sig = mod_s[MOD_STEPS].sig;
		for (int a = 0; a < 3; a++) begin
			f1_nx.len[a] = mod_s[MOD_STEPS].ax[a].len;
			if (mod_s[MOD_STEPS].ax[a].neg && mod_s[MOD_STEPS].ax[a].rem != '0) begin
				f1_nx.m0[a] = mod_s[MOD_STEPS].ax[a].len - {1'b0, mod_s[MOD_STEPS].ax[a].rem};
			end else begin
				f1_nx.m0[a] = {1'b0, mod_s[MOD_STEPS].ax[a].rem};
			end
		end
	end

	always_comb begin
		f2_nx.sig = f1_s.sig;
		for (int a = 0; a < 3; a++) begin
			if ({f1_s.m0[a], 1'b0} > {1'b0, f1_s.len[a]}) begin
				f2_nx.mag[a] = 31'(f1_s.len[a] - f1_s.m0[a]);
				f2_nx.sgn[a] = 1'b1;
			end else begin
				f2_nx.mag[a] = f1_s.m0[a][30:0];
				f2_nx.sgn[a] = 1'b0;
			end
		end
	end

	always_comb begin
		sq_nx.g = f2_s;
		sq_nx.ss = f2_s.sig * f2_s.sig;
		for (int a = 0; a < 3; a++) begin
			sq_nx.sq[a] = 61'(f2_s.mag[a] * f2_s.mag[a]);
		end
	end

	always_comb begin
		sum_nx.g = sq_s.g;
		sum_nx.ss = sq_s.ss;
		sum_nx.r2 = {1'b0, sq_s.sq[0]} + {1'b0, sq_s.sq[1]} + {1'b0, sq_s.sq[2]};
	end

	always_comb begin
		rt_in.rem = '0;
		rt_in.root = '0;
		rt_in.rad = sum_s.r2;
		rt_in.contact = (sum_s.g.sig != '0) && ({2'b00, sum_s.r2} < sum_s.ss);
		rt_in.g = sum_s.g;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f1_s <= f1_nx;
			f2_s <= f2_nx;
			sq_s <= sq_nx;
			sum_s <= sum_nx;
			rt_s[0] <= rt_in;
		end
	end

	// integer square root, one result bit per stage
	for (genvar j = 1; j <= ROOT_STEPS; j++) begin : g_root
		rt_t         nx;
		logic [33:0] cur;
		logic [33:0] trial;
		always_comb begin
			nx = rt_s[j-1];
			cur = {rt_s[j-1].rem, rt_s[j-1].rad[61:60]};
			trial = {1'b0, rt_s[j-1].root, 2'b01};
			if (cur >= trial) begin
				nx.rem = 32'(cur - trial);
				nx.root = {rt_s[j-1].root[29:0], 1'b1};
			end else begin
				nx.rem = cur[31:0];
				nx.root = {rt_s[j-1].root[29:0], 1'b0};
			end
			nx.rad = {rt_s[j-1].rad[59:0], 2'b00};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[j] <= nx;
			end
		end
	end

	// set up overlap and unit-vector quotients
	always_comb begin
		diff = rt_s[ROOT_STEPS].g.sig - {1'b0, rt_s[ROOT_STEPS].root};
		tu_in.trem = {1'b0, diff[31:1]};
		tu_in.tbits = {diff[0], 24'd0};
		tu_in.tq = '0;
		tu_in.root = rt_s[ROOT_STEPS].root;
		tu_in.rz = (rt_s[ROOT_STEPS].root == '0);
		tu_in.contact = rt_s[ROOT_STEPS].contact;
		tu_in.sgn = rt_s[ROOT_STEPS].g.sgn;
		tu_in.sig = rt_s[ROOT_STEPS].g.sig;
		for (int a = 0; a < 3; a++) begin
			tu_in.urem[a] = {1'b0, rt_s[ROOT_STEPS].g.mag[a][30:1]};
			tu_in.ubits[a] = {rt_s[ROOT_STEPS].g.mag[a][0], 24'd0};
			tu_in.uq[a] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tu_s[0] <= tu_in;
		end
	end

	for (genvar j = 1; j <= TU_STEPS; j++) begin : g_tu
		tu_t         nx;
		logic [32:0] tcur;
		logic [31:0] ucur [3];
		always_comb begin
			nx = tu_s[j-1];
			tcur = {tu_s[j-1].trem, tu_s[j-1].tbits[24]};
			if (tcur >= {1'b0, tu_s[j-1].sig}) begin
				nx.trem = 32'(tcur - {1'b0, tu_s[j-1].sig});
				nx.tq = {tu_s[j-1].tq[23:0], 1'b1};
			end else begin
				nx.trem = tcur[31:0];
				nx.tq = {tu_s[j-1].tq[23:0], 1'b0};
			end
			nx.tbits = {tu_s[j-1].tbits[23:0], 1'b0};
			for (int a = 0; a < 3; a++) begin
				ucur[a] = {tu_s[j-1].urem[a], tu_s[j-1].ubits[a][24]};
				if (ucur[a] >= {1'b0, tu_s[j-1].root}) begin
					nx.urem[a] = 31'(ucur[a] - {1'b0, tu_s[j-1].root});
					nx.uq[a] = {tu_s[j-1].uq[a][23:0], 1'b1};
				end else begin
					nx.urem[a] = ucur[a][30:0];
					nx.uq[a] = {tu_s[j-1].uq[a][23:0], 1'b0};
				end
				nx.ubits[a] = {tu_s[j-1].ubits[a][23:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				tu_s[j] <= nx;
			end
		end
	end

	// stiffness times overlap, overlap squared
	always_comb begin
		x_nx.p = 55'(stiff_q * tu_s[TU_STEPS].tq);
		tt = tu_s[TU_STEPS].tq * tu_s[TU_STEPS].tq;
		x_nx.t2 = tt[48:24];
		x_nx.u = tu_s[TU_STEPS].uq;
		x_nx.rz = tu_s[TU_STEPS].rz;
		x_nx.contact = tu_s[TU_STEPS].contact;
		x_nx.sgn = tu_s[TU_STEPS].sgn;
		x_nx.sig = tu_s[TU_STEPS].sig;
	end

	always_comb begin
		eprod = stiff_q * x_s.t2;
		k_in.energy = eprod[55:25];
		k_in.krem = '0;
		k_in.kbits = x_s.p;
		k_in.kq = '0;
		k_in.u = x_s.u;
		k_in.rz = x_s.rz;
		k_in.contact = x_s.contact;
		k_in.sgn = x_s.sgn;
		k_in.sig = x_s.sig;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s <= x_nx;
			k_s[0] <= k_in;
		end
	end

	// force magnitude quotient
	for (genvar j = 1; j <= K_STEPS; j++) begin : g_k
		k_t          nx;
		logic [32:0] kcur;
		always_comb begin
			nx = k_s[j-1];
			kcur = {k_s[j-1].krem, k_s[j-1].kbits[54]};
			if (kcur >= {1'b0, k_s[j-1].sig}) begin
				nx.krem = 32'(kcur - {1'b0, k_s[j-1].sig});
				nx.kq = {k_s[j-1].kq[53:0], 1'b1};
			end else begin
				nx.krem = kcur[31:0];
				nx.kq = {k_s[j-1].kq[53:0], 1'b0};
			end
			nx.kbits = {k_s[j-1].kbits[53:0], 1'b0};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				k_s[j] <= nx;
			end
		end
	end

	// per-axis force, split in high and low partial products
	always_comb begin
		fm_nx.energy = k_s[K_STEPS].energy;
		fm_nx.rz = k_s[K_STEPS].rz;
		fm_nx.contact = k_s[K_STEPS].contact;
		fm_nx.sgn = k_s[K_STEPS].sgn;
		for (int a = 0; a < 3; a++) begin
			fm_nx.hi[a] = k_s[K_STEPS].kq[54:24] * k_s[K_STEPS].u[a];
			lp[a] = k_s[K_STEPS].kq[23:0] * k_s[K_STEPS].u[a];
			fm_nx.lo[a] = lp[a][48:24];
		end
	end

	always_comb begin
		fs_nx.energy = fm_s.energy;
		fs_nx.rz = fm_s.rz;
		fs_nx.contact = fm_s.contact;
		fs_nx.sgn = fm_s.sgn;
		for (int a = 0; a < 3; a++) begin
			fs_nx.prod[a] = fm_s.hi[a] + {31'd0, fm_s.lo[a]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fm_s <= fm_nx;
			fs_s <= fs_nx;
		end
	end

	// sign, saturation and gating
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pm[a] = (fs_s.prod[a] > 56'h8000_0000) ? 32'h8000_0000 : fs_s.prod[a][31:0];
			if (!fs_s.contact || fs_s.rz) begin
				frc[a] = '0;
			end else if (!fs_s.sgn[a]) begin
				frc[a] = (fs_s.prod[a] > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : fs_s.prod[a][31:0];
			end else begin
				frc[a] = 32'(-pm[a]);
			end
		end
		out_nx.force_x = frc[0];
		out_nx.force_y = frc[1];
		out_nx.force_z = frc[2];
		out_nx.pair_energy = fs_s.contact ? {1'b0, fs_s.energy} : 32'd0;
		out_nx.in_contact = fs_s.contact;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= out_nx;
		end
	end

endmodule

/* verif/tb_harmonic_pair_force_core.sv */
// self-checking testbench for the harmonic pair force core: directed and random pairs
`timescale 1ns / 1ps
module tb_harmonic_pair_force_core;
	import hpf_pkg::*;

	localparam int LATENCY = 160;
	localparam longint LIMIT = 1200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hpf_cfg_if cfg_ch();
	hpf_pair_if pair_ch();
	hpf_res_if res_ch();

	harmonic_pair_force_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch.sink),
		.pair(pair_ch.sink),
		.result(res_ch.source)
	);

	always #5 clk = ~clk;

	logic [30:0] box_x, box_y, box_z, eps;
	pair_t pending_pairs[$];
	res_t expected_forces[$];
	int send_idle_pct, recv_idle_pct;
	bit hold_sender;
	int mismatches;
	longint cycle_count;

	function automatic longint wrap_axis(longint d, logic [30:0] side);
		longint len, m;
		len = (side == 0) ? (longint'(1) << 31) : longint'(side);
		m = d % len;
		if (m < 0) m += len;
		if (2 * m > len) m -= len;
		return m;
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] axis_push(longint unsigned k, longint d, longint unsigned r);
		longint unsigned mag, u, prod;
		if (r == 0) return 32'd0;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		u = (mag << 24) / r;
		prod = (k >> 24) * u + (((k & 64'hFFFFFF) * u) >> 24);
		if (d >= 0) return (prod > 64'h7FFFFFFF) ? 32'h7FFFFFFF : prod[31:0];
		if (prod > 64'h80000000) prod = 64'h80000000;
		return 32'(64'd0 - prod);
	endfunction

	function automatic res_t contact_force(pair_t p);
		res_t o;
		longint dx, dy, dz;
		longint unsigned sig, r2, r, t, k, t2, en;
		dx = wrap_axis(longint'(p.first_x) - longint'(p.second_x), box_x);
		dy = wrap_axis(longint'(p.first_y) - longint'(p.second_y), box_y);
		dz = wrap_axis(longint'(p.first_z) - longint'(p.second_z), box_z);
		sig = longint'(p.first_radius) + longint'(p.second_radius);
		r2 = dx * dx + dy * dy + dz * dz;
		o = '0;
		if (sig == 0 || r2 >= sig * sig) return o;
		r = isqrt(r2);
		t = ((sig - r) << 24) / sig;
		k = (longint'(eps) * t) / sig;
		o.force_x = axis_push(k, dx, r);
		o.force_y = axis_push(k, dy, r);
		o.force_z = axis_push(k, dz, r);
		t2 = (t * t) >> 24;
		en = (longint'(eps) * t2) >> 25;
		o.pair_energy = (en > 64'hFFFFFFFF) ? 32'hFFFFFFFF : en[31:0];
		o.in_contact = 1'b1;
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_ch.valid <= 1'b0;
			pair_ch.data <= '0;
		end else begin
			if (pair_ch.valid && pair_ch.ready) begin
				expected_forces.push_back(contact_force(pair_ch.data));
			end
			if (!pair_ch.valid || pair_ch.ready) begin
				if (pending_pairs.size() > 0 && !hold_sender
						&& $urandom_range(99) >= send_idle_pct) begin
					pair_ch.valid <= 1'b1;
					pair_ch.data <= pending_pairs.pop_front();
				end else begin
					pair_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_forces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", res_ch.data);
				end else begin
					res_t e;
					e = expected_forces.pop_front();
					if (e.force_x !== res_ch.data.force_x || e.force_y !== res_ch.data.force_y
							|| e.force_z !== res_ch.data.force_z
							|| e.pair_energy !== res_ch.data.pair_energy
							|| e.in_contact !== res_ch.data.in_contact) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %p got %p", e, res_ch.data);
					end
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [30:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_BOX_X: box_x = val;
			CFG_BOX_Y: box_y = val;
			CFG_BOX_Z: box_z = val;
			CFG_STIFF: eps = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_pairs.size() > 0 || pair_ch.valid || expected_forces.size() > 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd32();
		return $urandom;
	endfunction

	// pair near the first particle so overlaps are common
	function automatic pair_t near_pair(logic [30:0] rmax);
		pair_t p;
		int sp;
		sp = $urandom_range(2) == 0 ? 26 : 24;
		p.first_x = rnd32();
		p.first_y = rnd32();
		p.first_z = rnd32();
		p.second_x = p.first_x + ($signed(rnd32()) >>> (32 - sp));
		p.second_y = p.first_y + ($signed(rnd32()) >>> (32 - sp));
		p.second_z = p.first_z + ($signed(rnd32()) >>> (32 - sp));
		p.first_radius = 31'($urandom_range(rmax));
		p.second_radius = 31'($urandom_range(rmax));
		return p;
	endfunction

	function automatic pair_t any_pair();
		pair_t p;
		p.first_x = rnd32(); p.first_y = rnd32(); p.first_z = rnd32();
		p.second_x = rnd32(); p.second_y = rnd32(); p.second_z = rnd32();
		p.first_radius = 31'(rnd32()); p.second_radius = 31'(rnd32());
		return p;
	endfunction

	task automatic random_phase(int n, logic [30:0] rmax);
		pair_t p;
		repeat (n) begin
			p = ($urandom_range(9) < 8) ? near_pair(rmax) : any_pair();
			pending_pairs.push_back(p);
		end
		drain();
	endtask

	initial begin
		pair_t p;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BOX_X;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		pair_ch.valid = 1'b0;
		hold_sender = 1'b0;
		send_idle_pct = 30;
		recv_idle_pct = 85;
		mismatches = 0;
		cycle_count = 0;
		box_x = ONE_Q24; box_y = ONE_Q24; box_z = ONE_Q24; eps = ONE_Q24;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: coincident, no overlap, zero radii, extremes
		p = '0;
		p.first_radius = ONE_Q24 >> 2; p.second_radius = ONE_Q24 >> 2;
		pending_pairs.push_back(p);
		p.second_x = 32'h0040_0000;
		pending_pairs.push_back(p);
		p.second_x = -32'sh0040_0000; p.second_y = 32'h0010_0000;
		pending_pairs.push_back(p);
		p.second_x = 32'h0080_0000; p.second_y = 0;
		pending_pairs.push_back(p);
		p = '0; p.second_z = 32'h0000_1000;
		pending_pairs.push_back(p);
		p.first_x = 32'h7FFF_FFFF; p.second_x = 32'h8000_0000;
		p.first_y = 32'h8000_0000; p.second_y = 32'h7FFF_FFFF;
		p.first_z = 32'hFFFF_FFFF; p.second_z = 32'h0;
		p.first_radius = 31'h7FFF_FFFF; p.second_radius = 31'h7FFF_FFFF;
		pending_pairs.push_back(p);
		p.first_radius = 31'd1; p.second_radius = 31'd0;
		pending_pairs.push_back(p);
		p = '0; p.first_radius = 31'h7FFF_FFFF; p.second_radius = 31'h7FFF_FFFF;
		p.second_x = 32'h0000_0001;
		pending_pairs.push_back(p);
		drain();

		write_reg(CFG_STIFF, 31'h7FFF_FFFF);
		write_reg(CFG_BOX_X, 31'd0);
		write_reg(CFG_BOX_Y, 31'h7FFF_FFFF);
		write_reg(CFG_BOX_Z, 31'd1);
		pending_pairs.push_back(p);
		p.second_x = 32'h0100_0000; p.second_y = -32'sh0100_0000;
		pending_pairs.push_back(p);
		p = near_pair(31'h7FFF_FFFF);
		pending_pairs.push_back(p);
		drain();
		random_phase(250, 31'h0200_0000);

		// pause the sender until everything is out
		write_reg(CFG_STIFF, 31'd0);
		write_reg(CFG_BOX_X, 31'h0300_0000);
		write_reg(CFG_BOX_Y, 31'h0280_0000);
		write_reg(CFG_BOX_Z, 31'd1);
		repeat (20) pending_pairs.push_back(near_pair(31'h0100_0000));
		while (pending_pairs.size() > 0) @(posedge clk);
		hold_sender = 1'b1;
		repeat (20) pending_pairs.push_back(near_pair(31'h0100_0000));
		while (pair_ch.valid || expected_forces.size() > 0) @(posedge clk);
		hold_sender = 1'b0;
		random_phase(200, 31'h0100_0000);

		send_idle_pct = 85;
		recv_idle_pct = 30;
		write_reg(CFG_STIFF, 31'($urandom_range(31'h7FFF_FFFF)));
		write_reg(CFG_BOX_X, 31'($urandom_range(31'h7FFF_FFFF)));
		write_reg(CFG_BOX_Y, 31'($urandom_range(31'h0800_0000)));
		write_reg(CFG_BOX_Z, 31'h0400_0000);
		random_phase(450, 31'h0400_0000);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_STIFF, ONE_Q24);
		write_reg(CFG_BOX_X, ONE_Q24);
		write_reg(CFG_BOX_Y, ONE_Q24);
		write_reg(CFG_BOX_Z, ONE_Q24);
		random_phase(300, 31'h0080_0000);
		write_reg(CFG_STIFF, 31'h0A00_0000);
		write_reg(CFG_BOX_X, 31'h7FFF_FFFF);
		random_phase(230, 31'h7FFF_FFFF);

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
